### hw/rtl/lwkd_pkg.sv
package lwkd_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int ALPHABET = 128;

    localparam int CHAR_W = 7;
    localparam int SYM_W  = $clog2(ALPHABET);
    localparam int POS_W  = $clog2(MAX_LEN);
    localparam int LEN_W  = POS_W + 1;
    localparam int DIST_W = 8;

    localparam logic [DIST_W-1:0] MAX_DISTINCT_RESET = DIST_W'(2);

    localparam int S_TDATA_W = ((CHAR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((POS_W + LEN_W + 7) / 8) * 8;

    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic rd_en;
        sym_t rd_addr;
        logic wr_en;
        sym_t wr_addr;
        len_t wr_data;
        logic clear;
    } cnt_ctrl_t;

endpackage

### hw/rtl/longest_window_at_most_k_distinct.sv
// Longest window holding at most max_distinct distinct characters.
// The slave channel takes one character per item in s_tdata; s_tuser marks
// the first character of a new string, which clears the string state and
// the count table (its valid bits are cleared at once, no sweep needed).
// Each accepted item yields one result item on the master channel: the best
// window start and length so far, and the overflow flag in m_tuser.
// max_distinct is written through cfg_wen/cfg_wdata, and the user is to write
// it only while the block is idle; the block itself leaves this unenforced.
// The result is offered once the sequencer has gone through the check, the
// add, the shrink test and the removal of each character that leaves the
// window; each removal is a history read, a count read and a count update
// through the one shared update path. An item arriving when the string is
// already full goes from the check straight to the result and sets overflow.
// s_tready is high only while the sequencer is idle. The result waits in an
// output register; a new item may be accepted meanwhile, but its result is
// held back until the receiver has taken the previous one.
// After reset max_distinct is 2 and all string state is zero.
module longest_window_at_most_k_distinct
    import lwkd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // character
    input  logic                 s_tuser,   // start_of_string
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // best_start, best_length
    output logic                 m_tuser,   // overflow
    input  logic                 cfg_wen,
    input  logic [DIST_W-1:0]    cfg_wdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_ADD    = 3'd2;
    localparam logic [2:0] ST_SHRINK = 3'd3;
    localparam logic [2:0] ST_HREAD  = 3'd4;
    localparam logic [2:0] ST_CREAD  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    sym_t              ch_reg, ch_next;
    logic [DIST_W-1:0] max_distinct_reg;
    logic [DIST_W-1:0] distinct_reg, distinct_next;
    len_t              begin_reg, begin_next;
    len_t              end_reg, end_next;
    pos_t              best_begin_reg, best_begin_next;
    len_t              best_len_reg, best_len_next;
    logic              overflowed_reg, overflowed_next;
    logic              m_valid_reg, m_valid_next;
    pos_t              out_start_reg, out_start_next;
    len_t              out_len_reg, out_len_next;
    logic              out_ovf_reg, out_ovf_next;

    cnt_ctrl_t cnt_ctrl;
    len_t      cnt_rd;
    logic      hist_wr_en;
    logic      hist_rd_en;
    sym_t      hist_rd;
    len_t      upd_sum;
    len_t      win_len;
    logic      accept;

    lwkd_count_table u_count_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (cnt_ctrl),
        .rd_count (cnt_rd)
    );

    lwkd_history u_history (
        .aclk    (aclk),
        .wr_en   (hist_wr_en),
        .wr_addr (end_reg[POS_W-1:0]),
        .wr_data (ch_reg),
        .rd_en   (hist_rd_en),
        .rd_addr (begin_reg[POS_W-1:0]),
        .rd_data (hist_rd)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign win_len  = end_reg - begin_reg;

    // Shared count update: increment when a character enters, decrement when
    // one leaves.
    assign upd_sum = (state_reg == ST_ADD) ? cnt_rd + len_t'(1) : cnt_rd - len_t'(1);

    always_comb begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        distinct_next   = distinct_reg;
        begin_next      = begin_reg;
        end_next        = end_reg;
        best_begin_next = best_begin_reg;
        best_len_next   = best_len_reg;
        overflowed_next = overflowed_reg;
        m_valid_next    = m_valid_reg;
        out_start_next  = out_start_reg;
        out_len_next    = out_len_reg;
        out_ovf_next    = out_ovf_reg;
        cnt_ctrl        = '0;
        hist_wr_en      = 1'b0;
        hist_rd_en      = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ch_next    = s_tdata[SYM_W-1:0];
                    state_next = ST_CHECK;
                    if (s_tuser) begin
                        cnt_ctrl.clear  = 1'b1;
                        distinct_next   = '0;
                        begin_next      = '0;
                        end_next        = '0;
                        best_begin_next = '0;
                        best_len_next   = '0;
                        overflowed_next = 1'b0;
                    end
                end
            end
            ST_CHECK: begin
                if (end_reg == len_t'(MAX_LEN)) begin
                    overflowed_next = 1'b1;
                    state_next      = ST_DONE;
                end else begin
                    hist_wr_en       = 1'b1;
                    cnt_ctrl.rd_en   = 1'b1;
                    cnt_ctrl.rd_addr = ch_reg;
                    state_next       = ST_ADD;
                end
            end
            ST_ADD: begin
                if (cnt_rd == '0) begin
                    distinct_next = distinct_reg + DIST_W'(1);
                end
                cnt_ctrl.wr_en   = 1'b1;
                cnt_ctrl.wr_addr = ch_reg;
                cnt_ctrl.wr_data = upd_sum;
                end_next         = end_reg + len_t'(1);
                state_next       = ST_SHRINK;
            end
            ST_SHRINK: begin
                if (distinct_reg > max_distinct_reg && begin_reg < end_reg) begin
                    hist_rd_en = 1'b1;
                    state_next = ST_HREAD;
                end else begin
                    if (win_len >= best_len_reg) begin
                        best_len_next   = win_len;
                        best_begin_next = begin_reg[POS_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_HREAD: begin
                cnt_ctrl.rd_en   = 1'b1;
                cnt_ctrl.rd_addr = hist_rd;
                state_next       = ST_CREAD;
            end
            ST_CREAD: begin
                if (cnt_rd == len_t'(1)) begin
                    distinct_next = distinct_reg - DIST_W'(1);
                end
                if (cnt_rd != '0) begin
                    cnt_ctrl.wr_en   = 1'b1;
                    cnt_ctrl.wr_addr = hist_rd;
                    cnt_ctrl.wr_data = upd_sum;
                end
                begin_next = begin_reg + len_t'(1);
                state_next = ST_SHRINK;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    out_start_next = best_begin_reg;
                    out_len_next   = best_len_reg;
                    out_ovf_next   = overflowed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            max_distinct_reg <= MAX_DISTINCT_RESET;
            distinct_reg     <= '0;
            begin_reg        <= '0;
            end_reg          <= '0;
            best_begin_reg   <= '0;
            best_len_reg     <= '0;
            overflowed_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            distinct_reg   <= distinct_next;
            begin_reg      <= begin_next;
            end_reg        <= end_next;
            best_begin_reg <= best_begin_next;
            best_len_reg   <= best_len_next;
            overflowed_reg <= overflowed_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wen) begin
                max_distinct_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg        <= ch_next;
        out_start_reg <= out_start_next;
        out_len_reg   <= out_len_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - POS_W - LEN_W){1'b0}}, out_len_reg, out_start_reg};
    assign m_tuser  = out_ovf_reg;

endmodule

### hw/rtl/lwkd_count_table.sv
module lwkd_count_table
    import lwkd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cnt_ctrl_t ctrl,
    output len_t      rd_count
);

    len_t                  mem [ALPHABET];
    logic [ALPHABET-1:0]   valid_reg;
    len_t                  rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                valid_reg <= '0;
            end else if (ctrl.wr_en) begin
                valid_reg[ctrl.wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                rd_valid_reg <= valid_reg[ctrl.rd_addr];
            end
        end
    end

    assign rd_count = rd_valid_reg ? rd_data_reg : '0;

endmodule

### hw/rtl/lwkd_history.sv
module lwkd_history
    import lwkd_pkg::*;
(
    input  logic aclk,
    input  logic wr_en,
    input  pos_t wr_addr,
    input  sym_t wr_data,
    input  logic rd_en,
    input  pos_t rd_addr,
    output sym_t rd_data
);

    sym_t mem [MAX_LEN];
    sym_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
